// File: src/cvd_pkg.sv
package cvd_pkg;

  localparam int DEF_MAX_BLOCKS_WIDE = 256;
  localparam int DEF_MAX_BLOCKS_HIGH = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [1:0] BK_SOLID = 2'd0;
  localparam logic [1:0] BK_TWO   = 2'd1;
  localparam logic [1:0] BK_EIGHT = 2'd2;

  localparam logic [1:0] REG_WIDE    = 2'd0;
  localparam logic [1:0] REG_HIGH    = 2'd1;
  localparam logic [1:0] REG_PALETTE = 2'd2;

  localparam logic [7:0] SKIP_MASK  = 8'hFC;
  localparam logic [7:0] SKIP_CODE  = 8'h84;
  localparam logic [7:0] SOLID_BASE = 8'h80;
  localparam logic [7:0] EIGHT_BASE = 8'h90;
  localparam int         EIGHT_FLAG = 15;

  typedef enum logic {
    F_BYTE,
    F_SKIP
  } front_state_t;

  typedef struct packed {
    logic              has_blk;
    logic              has_st;
    logic              st_ok;
    logic [1:0]        bkind;
    logic [15:0]       value;
    logic [15:0]       cw;
    logic [7:0][15:0]  colors;
    logic [7:0]        col;
    logic [7:0]        row;
  } cmd_t;

endpackage

// File: src/cram_4x4_block_video_decoder.sv
// Decoder for 4x4-block CRAM frames, fed one byte of the compressed chunk per word.
// The byte channel (byte_valid, byte_stall) takes data_byte and end_of_chunk; a
// word moves at a clock edge with valid high and stall low. Each decoded block
// gives sixteen pixel words on the result channel, bottom block row first, and
// the byte marked end_of_chunk adds a status word (ok or corrupt); last marks
// the final word that a byte causes.
// The front parser takes one byte per cycle while its two-entry command queue
// has room and no skip is in progress. The back end sends one result word per
// cycle while result_stall is low. A completed block's command passes through
// the queue and the back end's current-command register before its first
// result word is registered. A skip code holds the byte channel while the
// parser steps over the skipped blocks a block row at a time, and longer while
// its end-of-chunk status word waits for room in the queue.
// The configuration port writes the frame width and height in blocks and
// palette_mode by index; write it only while the block is idle.
// Synchronous reset clears the queue and the parser and restores the register
// defaults (80 by 60 blocks, RGB555). A stall on the result channel holds the
// output word; the queue then fills and byte_stall rises.
module cram_4x4_block_video_decoder import cvd_pkg::*; #(
  parameter int MAX_BLOCKS_WIDE = DEF_MAX_BLOCKS_WIDE,
  parameter int MAX_BLOCKS_HIGH = DEF_MAX_BLOCKS_HIGH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_chunk,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [9:0]  pixel_col,
  output logic [9:0]  pixel_row,
  output logic [15:0] pixel_value,
  output logic        last
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  cvd_front #(
    .MAX_BLOCKS_WIDE(MAX_BLOCKS_WIDE),
    .MAX_BLOCKS_HIGH(MAX_BLOCKS_HIGH)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .data_byte(data_byte), .end_of_chunk(end_of_chunk),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  cvd_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  cvd_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .pixel_col(pixel_col), .pixel_row(pixel_row),
    .pixel_value(pixel_value), .last(last)
  );

endmodule

// File: src/cvd_front.sv
module cvd_front import cvd_pkg::*; #(
  parameter int MAX_BLOCKS_WIDE = DEF_MAX_BLOCKS_WIDE,
  parameter int MAX_BLOCKS_HIGH = DEF_MAX_BLOCKS_HIGH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_chunk,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CW = (MAX_BLOCKS_WIDE > 1) ? $clog2(MAX_BLOCKS_WIDE) : 1;
  localparam int RW = $clog2(MAX_BLOCKS_HIGH + 1);

  logic [8:0] width_blocks, height_blocks;
  logic       palette_mode;

  front_state_t     state, state_next;
  logic [4:0]       phase, phase_next;
  logic [15:0]      cw, cw_next;
  logic [7:0][15:0] colors, colors_next;
  logic [1:0]       bkind, bkind_next;
  logic [CW-1:0]    col, col_next;
  logic [RW-1:0]    row_left, row_left_next;
  logic [9:0]       skip_left, skip_left_next;
  logic             frame_done, frame_done_next;
  logic             eoc_pend, eoc_pend_next;

  logic [10:0] eff_w, eff_h, col_ext, step;
  logic        accept, emit, wraps, skip_done;
  logic [3:0]  k;
  logic [9:0]  n_skip;

  always_comb begin
    if (width_blocks == 9'd0) eff_w = 11'd1;
    else if ({2'b0, width_blocks} > 11'(MAX_BLOCKS_WIDE)) eff_w = 11'(MAX_BLOCKS_WIDE);
    else eff_w = {2'b0, width_blocks};
    if (height_blocks == 9'd0) eff_h = 11'd1;
    else if ({2'b0, height_blocks} > 11'(MAX_BLOCKS_HIGH)) eff_h = 11'(MAX_BLOCKS_HIGH);
    else eff_h = {2'b0, height_blocks};
  end

  assign col_ext   = 11'(col);
  assign wraps     = (col_ext + 11'd1) >= eff_w;
  assign step      = wraps ? 11'd1 : (eff_w - col_ext);
  assign skip_done = (skip_left == 10'd0) || frame_done;
  assign byte_stall = (state != F_BYTE) || q_full;
  assign accept     = byte_valid && !byte_stall;
  assign k          = 4'(phase - 5'd2);
  assign n_skip     = {data_byte[1:0], cw[7:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      F_BYTE: begin
        if (accept && !frame_done && phase == 5'd1 &&
            (data_byte & SKIP_MASK) == SKIP_CODE && n_skip != 10'd0) begin
          state_next = F_SKIP;
        end
      end
      F_SKIP: begin
        if (skip_done && (!eoc_pend || !q_full)) state_next = F_BYTE;
      end
      default: state_next = F_BYTE;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    cw_next         = cw;
    colors_next     = colors;
    bkind_next      = bkind;
    col_next        = col;
    row_left_next   = row_left;
    skip_left_next  = skip_left;
    frame_done_next = frame_done;
    eoc_pend_next   = eoc_pend;
    emit            = 1'b0;
    q_push          = 1'b0;
    q_cmd           = '0;
    q_cmd.col       = 8'(col);
    q_cmd.row       = 8'(row_left);

    if (state == F_SKIP) begin
      if (!skip_done) begin
        if (11'(skip_left) >= step) begin
          col_next       = '0;
          row_left_next  = row_left - 1'b1;
          if (row_left == RW'(1)) frame_done_next = 1'b1;
          skip_left_next = skip_left - 10'(step);
        end else begin
          col_next       = CW'(col_ext + 11'(skip_left));
          skip_left_next = '0;
        end
      end else if (eoc_pend && !q_full) begin
        q_push          = 1'b1;
        q_cmd.has_st    = 1'b1;
        q_cmd.st_ok     = frame_done;
        eoc_pend_next   = 1'b0;
        skip_left_next  = '0;
        phase_next      = '0;
        cw_next         = '0;
        bkind_next      = BK_SOLID;
        col_next        = '0;
        row_left_next   = RW'(eff_h);
        frame_done_next = 1'b0;
      end else begin
        skip_left_next = '0;
      end
    end else if (accept) begin
      if (!frame_done) begin
        if (phase == 5'd0) begin
          cw_next    = {8'h00, data_byte};
          phase_next = 5'd1;
        end else if (phase == 5'd1) begin
          cw_next = {data_byte, cw[7:0]};
          if ((data_byte & SKIP_MASK) == SKIP_CODE) begin
            phase_next = 5'd0;
            if (n_skip == 10'd0) begin
              frame_done_next = 1'b1;
            end else begin
              skip_left_next = n_skip;
              eoc_pend_next  = end_of_chunk;
            end
          end else if (data_byte < SOLID_BASE) begin
            bkind_next = BK_TWO;
            phase_next = 5'd2;
          end else if (palette_mode && data_byte >= EIGHT_BASE) begin
            bkind_next = BK_EIGHT;
            phase_next = 5'd2;
          end else begin
            emit        = 1'b1;
            q_cmd.bkind = BK_SOLID;
            q_cmd.value = palette_mode ? {8'h00, cw[7:0]} : {data_byte, cw[7:0]};
            phase_next  = 5'd0;
          end
        end else begin
          phase_next = phase + 5'd1;
          if (palette_mode) begin
            colors_next[k[2:0]] = {8'h00, data_byte};
            if (k + 4'd1 >= ((bkind == BK_EIGHT) ? 4'd8 : 4'd2)) emit = 1'b1;
          end else begin
            if (k[0]) colors_next[k[3:1]] = {data_byte, colors[k[3:1]][7:0]};
            else colors_next[k[3:1]] = {8'h00, data_byte};
            if (k == 4'd3 && colors_next[0][EIGHT_FLAG]) bkind_next = BK_EIGHT;
            if (5'(k) + 5'd1 >= ((bkind_next == BK_EIGHT) ? 5'd16 : 5'd4)) emit = 1'b1;
          end
          q_cmd.bkind = bkind_next;
          if (emit) phase_next = 5'd0;
        end
        q_cmd.cw     = cw_next;
        q_cmd.colors = colors_next;
        if (emit) begin
          q_push        = 1'b1;
          q_cmd.has_blk = 1'b1;
          if (wraps) begin
            col_next      = '0;
            row_left_next = row_left - 1'b1;
            if (row_left == RW'(1)) frame_done_next = 1'b1;
          end else begin
            col_next = CW'(col_ext + 11'd1);
          end
        end
      end
      if (end_of_chunk && state_next == F_BYTE) begin
        q_push          = 1'b1;
        q_cmd.has_st    = 1'b1;
        q_cmd.st_ok     = frame_done_next;
        phase_next      = '0;
        cw_next         = '0;
        bkind_next      = BK_SOLID;
        col_next        = '0;
        row_left_next   = RW'(eff_h);
        skip_left_next  = '0;
        frame_done_next = 1'b0;
        eoc_pend_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_blocks  <= 9'd80;
      height_blocks <= 9'd60;
      palette_mode  <= 1'b0;
      state         <= F_BYTE;
      phase         <= '0;
      cw            <= '0;
      bkind         <= BK_SOLID;
      col           <= '0;
      row_left      <= RW'(60 > MAX_BLOCKS_HIGH ? MAX_BLOCKS_HIGH : 60);
      skip_left     <= '0;
      frame_done    <= 1'b0;
      eoc_pend      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WIDE:    width_blocks  <= cfg_data;
          REG_HIGH:    height_blocks <= cfg_data;
          REG_PALETTE: palette_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      state      <= state_next;
      phase      <= phase_next;
      cw         <= cw_next;
      bkind      <= bkind_next;
      col        <= col_next;
      row_left   <= row_left_next;
      skip_left  <= skip_left_next;
      frame_done <= frame_done_next;
      eoc_pend   <= eoc_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    colors <= colors_next;
  end

endmodule

// File: src/cvd_queue.sv
module cvd_queue import cvd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full  = count == (PW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// File: src/cvd_back.sv
module cvd_back import cvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [9:0]  pixel_col,
  output logic [9:0]  pixel_row,
  output logic [15:0] pixel_value,
  output logic        last
);

  cmd_t        cur;
  logic        busy;
  logic [4:0]  cnt;
  logic        emit, final_item, sel;
  logic [3:0]  pix;
  logic [15:0] val;

  assign emit       = busy && (!result_valid || !result_stall);
  assign final_item = cnt[4] || (cnt == 5'd15 && !cur.has_st);
  assign q_pop      = !q_empty && (!busy || (emit && final_item));
  assign pix        = cnt[3:0];
  assign sel        = ~cur.cw[pix];

  always_comb begin
    unique case (cur.bkind)
      BK_TWO:   val = cur.colors[{2'b00, sel}];
      BK_EIGHT: val = cur.colors[{pix[3], pix[1], sel}];
      default:  val = cur.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && final_item) begin
        busy <= 1'b0;
      end
      if (emit) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      cnt <= q_head.has_blk ? 5'd0 : 5'd16;
    end else if (emit) begin
      cnt <= cnt + 5'd1;
    end
    if (emit) begin
      last <= final_item;
      if (cnt[4]) begin
        kind        <= cur.st_ok ? KIND_OK : KIND_BAD;
        pixel_col   <= '0;
        pixel_row   <= '0;
        pixel_value <= '0;
      end else begin
        kind        <= KIND_PIXEL;
        pixel_col   <= {cur.col, pix[1:0]};
        pixel_row   <= {cur.row, 2'b00} - 10'd1 - {8'd0, pix[3:2]};
        pixel_value <= val;
      end
    end
  end

endmodule
